/* sv/npe_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// npe_pkg
// Shared types for the next-permutation engine: controller states, datapath
// operation codes and the status bundle returned by the datapath.
// ----------------------------------------------------------------------------
package npe_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN_LOAD,
    ST_SCAN_CMP,
    ST_FIND_CMP,
    ST_SWAP_WR,
    ST_REV_CHK,
    ST_REV_HI,
    ST_REV_WR_LO,
    ST_REV_WR_HI,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } npe_state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_PREP_ONE,
    OP_PREP_SCAN,
    OP_SCAN_LOAD,
    OP_SCAN_STEP,
    OP_PIV_HIT,
    OP_NO_PIV,
    OP_FIND_STEP,
    OP_FIND_HIT,
    OP_SWAP_WR,
    OP_REV_LO,
    OP_REV_HI,
    OP_REV_WR_LO,
    OP_REV_WR_HI,
    OP_EMIT_INIT,
    OP_EMIT_RD,
    OP_EMIT_STEP,
    OP_EMIT_END
  } npe_op_t;

  typedef struct packed {
    logic n_small;   // fewer than two elements stored
    logic rd_lt_prev; // read element below its right neighbour
    logic hold_lt_rd; // pivot value below read element
    logic a_zero;    // scan pointer at the first element
    logic lo_lt_hi;  // reversal pointers not yet crossed
    logic at_last;   // emit pointer on the final element
  } npe_stat_t;

endpackage : npe_pkg
`default_nettype wire

/* sv/npe_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// npe_ctrl
// Sequencer for the engine: load, pivot scan, successor search, swap,
// suffix reversal and emission, issued to the datapath as one op per cycle.
// ----------------------------------------------------------------------------
module npe_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              in_last,
  input  wire npe_pkg::npe_stat_t stat,
  output npe_pkg::npe_op_t       op,
  output logic                   busy,
  output logic                   out_valid
);

  npe_pkg::npe_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= npe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = npe_pkg::OP_NONE;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      npe_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          op = npe_pkg::OP_LOAD;
          if (in_last) begin
            state_nxt = npe_pkg::ST_PREP;
          end
        end
      end
      npe_pkg::ST_PREP: begin
        if (stat.n_small) begin
          op        = npe_pkg::OP_PREP_ONE;
          state_nxt = npe_pkg::ST_EMIT_RD;
        end else begin
          op        = npe_pkg::OP_PREP_SCAN;
          state_nxt = npe_pkg::ST_SCAN_LOAD;
        end
      end
      npe_pkg::ST_SCAN_LOAD: begin
        op        = npe_pkg::OP_SCAN_LOAD;
        state_nxt = npe_pkg::ST_SCAN_CMP;
      end
      npe_pkg::ST_SCAN_CMP: begin
        if (stat.rd_lt_prev) begin
          op        = npe_pkg::OP_PIV_HIT;
          state_nxt = npe_pkg::ST_FIND_CMP;
        end else if (stat.a_zero) begin
          op        = npe_pkg::OP_NO_PIV;
          state_nxt = npe_pkg::ST_REV_CHK;
        end else begin
          op = npe_pkg::OP_SCAN_STEP;
        end
      end
      npe_pkg::ST_FIND_CMP: begin
        if (stat.hold_lt_rd) begin
          op        = npe_pkg::OP_FIND_HIT;
          state_nxt = npe_pkg::ST_SWAP_WR;
        end else begin
          op = npe_pkg::OP_FIND_STEP;
        end
      end
      npe_pkg::ST_SWAP_WR: begin
        op        = npe_pkg::OP_SWAP_WR;
        state_nxt = npe_pkg::ST_REV_CHK;
      end
      npe_pkg::ST_REV_CHK: begin
        if (stat.lo_lt_hi) begin
          op        = npe_pkg::OP_REV_LO;
          state_nxt = npe_pkg::ST_REV_HI;
        end else begin
          op        = npe_pkg::OP_EMIT_INIT;
          state_nxt = npe_pkg::ST_EMIT_RD;
        end
      end
      npe_pkg::ST_REV_HI: begin
        op        = npe_pkg::OP_REV_HI;
        state_nxt = npe_pkg::ST_REV_WR_LO;
      end
      npe_pkg::ST_REV_WR_LO: begin
        op        = npe_pkg::OP_REV_WR_LO;
        state_nxt = npe_pkg::ST_REV_WR_HI;
      end
      npe_pkg::ST_REV_WR_HI: begin
        op        = npe_pkg::OP_REV_WR_HI;
        state_nxt = npe_pkg::ST_REV_CHK;
      end
      npe_pkg::ST_EMIT_RD: begin
        op        = npe_pkg::OP_EMIT_RD;
        state_nxt = npe_pkg::ST_EMIT_OUT;
      end
      npe_pkg::ST_EMIT_OUT: begin
        out_valid = 1'b1;
        if (stat.at_last) begin
          op        = npe_pkg::OP_EMIT_END;
          state_nxt = npe_pkg::ST_IDLE;
        end else begin
          op = npe_pkg::OP_EMIT_STEP;
        end
      end
      default: begin
        state_nxt = npe_pkg::ST_IDLE;
      end
    endcase
  end

endmodule : npe_ctrl
`default_nettype wire

/* sv/npe_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// npe_dp
// Element store, pointers and comparators. Executes one op per cycle; the
// store has one write and one registered read port.
// ----------------------------------------------------------------------------
module npe_dp #(
  parameter int unsigned MAX_LEN = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire npe_pkg::npe_op_t            op,
  input  wire logic signed [npe_pkg::DATA_W-1:0] in_value,
  output npe_pkg::npe_stat_t               stat,
  output logic signed [npe_pkg::DATA_W-1:0] out_value_res,
  output logic                             out_last_res,
  output logic                             out_wrapped,
  output logic                             out_too_long
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  logic signed [npe_pkg::DATA_W-1:0] mem [MAX_LEN];

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic          wrap_r, wrap_nxt;
  logic [AW-1:0] a_r, a_nxt;
  logic [AW-1:0] b_r, b_nxt;
  logic [AW-1:0] piv_r, piv_nxt;
  logic signed [npe_pkg::DATA_W-1:0] hold_r, hold_nxt;
  logic signed [npe_pkg::DATA_W-1:0] prev_r, prev_nxt;
  logic signed [npe_pkg::DATA_W-1:0] rd_r;

  logic [CW-1:0] cnt_m1, cnt_m2;
  logic [AW-1:0] last_idx;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic signed [npe_pkg::DATA_W-1:0] wdata;
  logic          we;

  assign cnt_m1   = cnt_r - CW'(1);
  assign cnt_m2   = cnt_r - CW'(2);
  assign last_idx = cnt_m1[AW-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wrap_r <= wrap_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    piv_r  <= piv_nxt;
    hold_r <= hold_nxt;
    prev_r <= prev_nxt;
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    wrap_nxt = wrap_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    piv_nxt  = piv_r;
    hold_nxt = hold_r;
    prev_nxt = prev_r;
    raddr    = a_r;
    waddr    = a_r;
    wdata    = rd_r;
    we       = 1'b0;
    unique case (op)
      npe_pkg::OP_NONE: begin
      end
      npe_pkg::OP_LOAD: begin
        if (cnt_r < CW'(MAX_LEN)) begin
          we      = 1'b1;
          waddr   = cnt_r[AW-1:0];
          wdata   = in_value;
          cnt_nxt = cnt_r + CW'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      npe_pkg::OP_PREP_ONE: begin
        wrap_nxt = 1'b1;
        a_nxt    = '0;
      end
      npe_pkg::OP_PREP_SCAN: begin
        raddr = last_idx;
        a_nxt = cnt_m2[AW-1:0];
      end
      npe_pkg::OP_SCAN_LOAD: begin
        prev_nxt = rd_r;
        raddr    = a_r;
      end
      npe_pkg::OP_SCAN_STEP: begin
        prev_nxt = rd_r;
        a_nxt    = a_r - AW'(1);
        raddr    = a_r - AW'(1);
      end
      npe_pkg::OP_PIV_HIT: begin
        piv_nxt  = a_r;
        hold_nxt = rd_r;
        b_nxt    = last_idx;
        raddr    = last_idx;
      end
      npe_pkg::OP_NO_PIV: begin
        wrap_nxt = 1'b1;
        a_nxt    = '0;
        b_nxt    = last_idx;
      end
      npe_pkg::OP_FIND_STEP: begin
        b_nxt = b_r - AW'(1);
        raddr = b_r - AW'(1);
      end
      npe_pkg::OP_FIND_HIT: begin
        // successor takes the pivot value; pivot slot written next cycle
        we       = 1'b1;
        waddr    = b_r;
        wdata    = hold_r;
        prev_nxt = rd_r;
      end
      npe_pkg::OP_SWAP_WR: begin
        we       = 1'b1;
        waddr    = piv_r;
        wdata    = prev_r;
        a_nxt    = piv_r + AW'(1);
        b_nxt    = last_idx;
        wrap_nxt = 1'b0;
      end
      npe_pkg::OP_REV_LO: begin
        raddr = a_r;
      end
      npe_pkg::OP_REV_HI: begin
        hold_nxt = rd_r;
        raddr    = b_r;
      end
      npe_pkg::OP_REV_WR_LO: begin
        we    = 1'b1;
        waddr = a_r;
        wdata = rd_r;
      end
      npe_pkg::OP_REV_WR_HI: begin
        we    = 1'b1;
        waddr = b_r;
        wdata = hold_r;
        a_nxt = a_r + AW'(1);
        b_nxt = b_r - AW'(1);
      end
      npe_pkg::OP_EMIT_INIT: begin
        a_nxt = '0;
      end
      npe_pkg::OP_EMIT_RD: begin
        raddr = a_r;
      end
      npe_pkg::OP_EMIT_STEP: begin
        a_nxt = a_r + AW'(1);
        raddr = a_r + AW'(1);
      end
      npe_pkg::OP_EMIT_END: begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.n_small    = (cnt_r <= CW'(1));
    stat.rd_lt_prev = (rd_r < prev_r);
    stat.hold_lt_rd = (hold_r < rd_r);
    stat.a_zero     = (a_r == '0);
    stat.lo_lt_hi   = (a_r < b_r);
    stat.at_last    = (a_r == last_idx);
  end

  assign out_value_res = rd_r;
  assign out_last_res  = stat.at_last;
  assign out_wrapped   = wrap_r;
  assign out_too_long  = ovf_r;

endmodule : npe_dp
`default_nettype wire

/* sv/next_permutation_engine_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// next_permutation_engine_top
// Streams in a sequence of signed words and streams out its next
// lexicographic permutation, or the ascending order when none is greater.
// ----------------------------------------------------------------------------
// Usage: pulse start with in_value/in_last while busy is low; each such cycle
// moves one beat. Up to MAX_LEN elements are kept; later ones are dropped and
// out_too_long is raised on every result beat. The beat with in_last set starts
// the rearrangement, during which busy stays high. It runs a pivot scan, then,
// when a pivot is found, a successor search, whose final step writes the first
// half of the swap, and the swap itself; then the suffix reversal, pair by pair
// with a closing check, and last the emission. The element store has a single
// read port. Results leave as consecutive beats, one per stored element, marked
// by out_valid; the receiver has no back-pressure, so it must take every beat in
// the cycle it appears. out_last_res marks the final one, and out_wrapped tells
// that the output is the ascending order. busy drops in the cycle after the
// last beat.
// ----------------------------------------------------------------------------
module next_permutation_engine_top #(
  parameter int unsigned MAX_LEN = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [npe_pkg::DATA_W-1:0] in_value,
  input  wire logic                              in_last,
  output logic                                   out_valid,
  output logic signed [npe_pkg::DATA_W-1:0]      out_value_res,
  output logic                                   out_last_res,
  output logic                                   out_wrapped,
  output logic                                   out_too_long
);

  npe_pkg::npe_op_t   op;
  npe_pkg::npe_stat_t stat;

  // sequencer: one datapath op per cycle
  npe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_last   (in_last),
    .stat      (stat),
    .op        (op),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // store, pointers and comparators
  npe_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .op            (op),
    .in_value      (in_value),
    .stat          (stat),
    .out_value_res (out_value_res),
    .out_last_res  (out_last_res),
    .out_wrapped   (out_wrapped),
    .out_too_long  (out_too_long)
  );

endmodule : next_permutation_engine_top
`default_nettype wire

/* verif/tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the next-permutation engine. Sequences of signed
// words go in one beat at a time; a scoreboard rebuilds the next lexicographic
// arrangement of each sequence and checks every result beat, field by field.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic signed [npe_pkg::DATA_W-1:0] value;
  logic                              last;
  logic                              wrapped;
  logic                              too_long;
} perm_beat_t;

class perm_scoreboard;
  int unsigned cap;
  logic signed [npe_pkg::DATA_W-1:0] held [];
  int unsigned held_count;
  bit dropped;
  perm_beat_t pending_beats [$];
  int unsigned fails, seqs, beats_in, beats_out, wraps, overflows;

  function new(int unsigned capacity);
    cap = capacity;
    held = new[capacity];
    held_count = 0;
    dropped = 1'b0;
    fails = 0;
    seqs = 0;
    beats_in = 0;
    beats_out = 0;
    wraps = 0;
    overflows = 0;
  endfunction

  // Rearrange the first n held words in place; return 1 when no greater
  // arrangement exists and the words end up ascending.
  function bit advance_arrangement(int unsigned n);
    logic signed [npe_pkg::DATA_W-1:0] tmp;
    int unsigned lo, hi, k;
    bit wrapped, found;
    wrapped = 1'b1;
    lo = 0;
    if (n >= 2) begin
      found = 1'b0;
      for (int i = n - 1; i > 0 && !found; i--) begin
        if (held[i-1] < held[i]) begin
          k = n - 1;
          while (!(held[i-1] < held[k])) k--;
          tmp = held[i-1];
          held[i-1] = held[k];
          held[k] = tmp;
          lo = i;
          wrapped = 1'b0;
          found = 1'b1;
        end
      end
      hi = n - 1;
      while (lo < hi) begin
        tmp = held[lo];
        held[lo] = held[hi];
        held[hi] = tmp;
        lo++;
        hi--;
      end
    end
    return wrapped;
  endfunction

  function void note_beat(logic signed [npe_pkg::DATA_W-1:0] value, logic last);
    perm_beat_t b;
    bit wrapped;
    beats_in++;
    if (held_count < cap) begin
      held[held_count] = value;
      held_count++;
    end else begin
      dropped = 1'b1;
    end
    if (last) begin
      wrapped = advance_arrangement(held_count);
      for (int k = 0; k < held_count; k++) begin
        b.value = held[k];
        b.last = (k + 1 == held_count);
        b.wrapped = wrapped;
        b.too_long = dropped;
        pending_beats.push_back(b);
      end
      seqs++;
      if (wrapped) wraps++;
      if (dropped) overflows++;
      held_count = 0;
      dropped = 1'b0;
    end
  endfunction

  function void mismatch(string field, logic signed [31:0] want, logic signed [31:0] got);
    if (fails < 40)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    fails++;
  endfunction

  function void check_beat(logic signed [npe_pkg::DATA_W-1:0] value, logic last,
                           logic wrapped, logic too_long);
    perm_beat_t want;
    beats_out++;
    if (pending_beats.size() == 0) begin
      if (fails < 40)
        $display("%0t: result beat with nothing expected, expected none, got %0d",
                 $time, value);
      fails++;
      return;
    end
    want = pending_beats.pop_front();
    if (value !== want.value) mismatch("value_res", want.value, value);
    if (last !== want.last) mismatch("last_res", want.last, last);
    if (wrapped !== want.wrapped) mismatch("wrapped", want.wrapped, wrapped);
    if (too_long !== want.too_long) mismatch("too_long", want.too_long, too_long);
  endfunction
endclass

module tb;

  localparam int unsigned SEQ_CAP      = 16;
  localparam int unsigned STALL_LIMIT  = 3000; // cycles with no beat either way
  localparam int unsigned DRAIN_CYCLES = 200;  // drain after the last expected beat, for stray beats
  localparam logic signed [npe_pkg::DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [npe_pkg::DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic signed [npe_pkg::DATA_W-1:0] in_value = '0;
  logic                              in_last = 1'b0;
  logic                              busy;
  logic                              out_valid;
  logic signed [npe_pkg::DATA_W-1:0] out_value_res;
  logic                              out_last_res;
  logic                              out_wrapped;
  logic                              out_too_long;

  perm_scoreboard                    sb;
  logic signed [npe_pkg::DATA_W-1:0] seq_words [$];
  int unsigned                       sender_idle_pct = 0;
  int unsigned                       words_sent = 0;
  int unsigned                       stall_cycles = 0;

  next_permutation_engine_top #(.MAX_LEN(SEQ_CAP)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_value_res (out_value_res),
    .out_last_res  (out_last_res),
    .out_wrapped   (out_wrapped),
    .out_too_long  (out_too_long)
  );

  always #4 clk = ~clk;

  // Sample both channels at the rising edge. A result beat is checked first,
  // then an accepted input beat is handed to the predictor. Any beat moving
  // either way clears the stall counter; too long without one ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1)
        sb.check_beat(out_value_res, out_last_res, out_wrapped, out_too_long);
      if (start && busy === 1'b0)
        sb.note_beat(in_value, in_last);
      if (out_valid === 1'b1 || (start && busy === 1'b0))
        stall_cycles = 0;
      else
        stall_cycles = stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Offer one word. Idle the sender for a random number of cycles first,
  // then present the beat at the falling edge and hold it until busy is low
  // at a rising edge.
  task automatic push_beat(input logic signed [npe_pkg::DATA_W-1:0] value,
                           input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start    <= 1'b1;
    in_value <= value;
    in_last  <= last;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    words_sent++;
  endtask

  // Send everything in seq_words, marking the final word as last.
  task automatic send_sequence();
    for (int k = 0; k < seq_words.size(); k++)
      push_beat(seq_words[k], k == seq_words.size() - 1);
  endtask

  // Build one random sequence. Most are short; some run up to the store's
  // capacity and a few overrun it so that words are dropped, the last beat among
  // them. Small value ranges give repeated words; a tenth are sorted
  // descending so that the wrap to ascending order turns up often.
  task automatic run_random_sequence();
    int unsigned pick, len, mode;
    logic signed [npe_pkg::DATA_W-1:0] w, tmp;
    pick = $urandom_range(99);
    if (pick < 70)      len = $urandom_range(6, 1);
    else if (pick < 90) len = $urandom_range(SEQ_CAP, 7);
    else                len = $urandom_range(SEQ_CAP + 4, SEQ_CAP + 1);
    mode = $urandom_range(2);
    seq_words.delete();
    for (int k = 0; k < len; k++) begin
      case (mode)
        0: w = $urandom;
        1: w = $signed($urandom_range(6)) - 3;
        default: begin
          case ($urandom_range(4))
            0: w = WORD_MIN;
            1: w = WORD_MAX;
            2: w = '0;
            3: w = -1;
            default: w = $urandom;
          endcase
        end
      endcase
      seq_words.push_back(w);
    end
    if ($urandom_range(9) == 0) begin
      for (int a = 1; a < seq_words.size(); a++) begin
        for (int b = a; b > 0 && seq_words[b-1] < seq_words[b]; b--) begin
          tmp = seq_words[b];
          seq_words[b] = seq_words[b-1];
          seq_words[b-1] = tmp;
        end
      end
    end
    send_sequence();
  endtask

  initial begin
    sb = new(SEQ_CAP);
    // Hold reset, then release it away from the rising edge.
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: lone extreme word, extremes in ascending order, a
    // strictly descending run that must wrap, equal words, and a sequence one
    // word over capacity so the last beat itself is dropped.
    sender_idle_pct = 27;
    seq_words = '{WORD_MAX};
    send_sequence();
    seq_words = '{WORD_MIN, WORD_MAX};
    send_sequence();
    seq_words = '{WORD_MAX, -1, WORD_MIN};
    send_sequence();
    seq_words = '{32'sd7, 32'sd7};
    send_sequence();
    seq_words.delete();
    for (int k = 0; k <= SEQ_CAP; k++)
      seq_words.push_back((k % 3 == 0) ? -k * 1000 : k);
    send_sequence();

    // Random part in three phases: moderate sender gaps, heavy gaps, none.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: sender_idle_pct = 27;
        1: sender_idle_pct = 57;
        default: sender_idle_pct = 0;
      endcase
      while (words_sent < 25 + (ph + 1) * 128) run_random_sequence();
    end

    // Drop start, wait for the last expected beat, then drain for strays.
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d sequences: %0d words in, %0d words out.",
             sb.seqs, sb.beats_in, sb.beats_out);
    $display("%0d sequences wrapped to ascending order, %0d overran the store.",
             sb.wraps, sb.overflows);
    if (sb.fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
sv/npe_pkg.sv
sv/npe_ctrl.sv
sv/npe_dp.sv
sv/next_permutation_engine_top.sv
verif/tb.sv
